// File: sv/lcd_text_glyph_streamer_defines.svh
// Assertion helpers for the glyph streamer
`ifndef LCD_TEXT_GLYPH_STREAMER_DEFINES_SVH
`define LCD_TEXT_GLYPH_STREAMER_DEFINES_SVH

// same-cycle implication
`define LTGS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LTGS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/ltgs_pkg.sv
package ltgs_pkg;

    localparam int SCREEN_WIDTH_DEF  = 128;
    localparam int SCREEN_HEIGHT_DEF = 160;
    localparam int GLYPH_COUNT_DEF   = 96;

    localparam int GLYPH_COLS = 5;
    localparam int GLYPH_ROWS = 8;
    localparam int STEP_X     = 6;
    localparam int STEP_Y     = 8;

    localparam logic [7:0] OP_ORIENT    = 8'h36;
    localparam logic [7:0] OP_COLWIN    = 8'h2A;
    localparam logic [7:0] OP_ROWWIN    = 8'h2B;
    localparam logic [7:0] OP_MEMWR     = 8'h2C;
    localparam logic [7:0] ORIENT_RESET = 8'hC8;
    localparam logic [6:0] FIRST_CODE   = 7'd32;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_DRAW = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [8:0]  font_address;
        logic [7:0]  font_byte;
        logic [6:0]  char_code;
        logic        string_start;
        logic [15:0] foreground_color;
        logic [15:0] background_color;
    } t_in_item;

    typedef struct packed {
        logic        is_data;
        logic        is_wide;
        logic [15:0] word;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic       we;
        logic [8:0] waddr;
        logic [7:0] wdata;
        logic [8:0] raddr;
    } t_mem_req;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ORIENT,
        ST_COLCMD,
        ST_X0,
        ST_X1,
        ST_ROWCMD,
        ST_Y0,
        ST_Y1,
        ST_MEMWR,
        ST_PIXEL
    } t_state;

endpackage

// File: sv/ltgs_font_mem.sv
module ltgs_font_mem #(
    parameter int GLYPH_COUNT = ltgs_pkg::GLYPH_COUNT_DEF
) (
    input  logic               i_clk,
    input  ltgs_pkg::t_mem_req i_req,
    output logic [7:0]         o_rd_data
);
    import ltgs_pkg::*;

    localparam int DEPTH = GLYPH_COUNT * GLYPH_COLS;
    localparam int AW    = $clog2(DEPTH);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr[AW-1:0]] <= i_req.wdata;
        end
        r_rd_data <= r_mem[i_req.raddr[AW-1:0]];
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: sv/ltgs_engine.sv
module ltgs_engine #(
    parameter int SCREEN_WIDTH  = ltgs_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = ltgs_pkg::SCREEN_HEIGHT_DEF,
    parameter int GLYPH_COUNT   = ltgs_pkg::GLYPH_COUNT_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  ltgs_pkg::t_in_item  i_item,
    input  logic [7:0]          i_orient,
    output logic                o_idle,
    output logic [8:0]          o_rd_addr,
    input  logic [7:0]          i_rd_data,
    output ltgs_pkg::t_out_item o_out,
    output logic                o_out_valid,
    input  logic                i_out_ready
);
    import ltgs_pkg::*;

    localparam logic [2:0] LAST_COL = 3'(GLYPH_COLS - 1);
    localparam logic [2:0] LAST_ROW = 3'(GLYPH_ROWS - 1);

    t_state     r_state, n_state;
    t_out_item  r_out, n_out;
    logic       r_out_valid, n_out_valid;
    logic [7:0] r_cx, n_cx, r_cy, n_cy;
    logic [7:0] r_sent, n_sent;
    logic [15:0] r_fg, n_fg, r_bg, n_bg;
    logic [2:0] r_pcol, n_pcol, r_prow, n_prow;

    logic       r_fetch_on, r_rd_pend, r_has_glyph;
    logic [2:0] r_fetch_idx, r_rd_col;
    logic [8:0] r_base;
    logic [7:0] r_cols [GLYPH_COLS];

    logic       slot_free, start_has_glyph, pix_bit, pix_last;
    logic [6:0] start_glyph;
    logic [9:0] wrap_nx, wrap_ny;

    assign start_glyph     = i_item.char_code - FIRST_CODE;
    assign start_has_glyph = (i_item.char_code >= FIRST_CODE) &&
                             ({1'b0, start_glyph} < 8'(GLYPH_COUNT));

    // column fetch runs alongside the header transfers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fetch_on <= 1'b0;
            r_rd_pend  <= 1'b0;
        end else begin
            if (i_start) begin
                r_fetch_on <= 1'b1;
            end else if (r_fetch_on && r_fetch_idx == LAST_COL) begin
                r_fetch_on <= 1'b0;
            end
            r_rd_pend <= r_fetch_on;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_fetch_idx <= '0;
            r_has_glyph <= start_has_glyph;
            r_base      <= start_has_glyph ?
                           (({2'b00, start_glyph} << 2) + {2'b00, start_glyph}) : '0;
        end else if (r_fetch_on) begin
            r_fetch_idx <= r_fetch_idx + 3'd1;
        end
        r_rd_col <= r_fetch_idx;
        if (r_rd_pend) begin
            r_cols[r_rd_col] <= r_has_glyph ? i_rd_data : 8'h00;
        end
    end

    assign o_rd_addr = r_base + {6'b0, r_fetch_idx};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_cx        <= 8'd1;
            r_cy        <= 8'd1;
            r_sent      <= ORIENT_RESET;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_cx        <= n_cx;
            r_cy        <= n_cy;
            r_sent      <= n_sent;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_fg   <= n_fg;
        r_bg   <= n_bg;
        r_pcol <= n_pcol;
        r_prow <= n_prow;
    end

    assign slot_free = !r_out_valid || i_out_ready;
    assign pix_bit   = r_cols[r_pcol][r_prow];
    assign pix_last  = (r_prow == LAST_ROW) && (r_pcol == LAST_COL);

    always_comb begin
        wrap_nx = {2'b00, r_cx} + 10'(STEP_X);
        wrap_ny = {2'b00, r_cy};
        if (wrap_nx + 10'(GLYPH_COLS - 1) >= 10'(SCREEN_WIDTH)) begin
            wrap_nx = 10'd1;
            wrap_ny = {2'b00, r_cy} + 10'(STEP_Y);
        end
        if (wrap_ny + 10'(GLYPH_ROWS - 1) >= 10'(SCREEN_HEIGHT)) begin
            wrap_ny = 10'd1;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        n_cx        = r_cx;
        n_cy        = r_cy;
        n_sent      = r_sent;
        n_fg        = r_fg;
        n_bg        = r_bg;
        n_pcol      = r_pcol;
        n_prow      = r_prow;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_fg   = i_item.foreground_color;
                    n_bg   = i_item.background_color;
                    n_pcol = '0;
                    n_prow = '0;
                    if (i_item.string_start) begin
                        n_cx = 8'd1;
                        n_cy = 8'd1;
                    end
                    n_state = (i_orient != r_sent) ? ST_ORIENT : ST_COLCMD;
                end
            end
            ST_ORIENT: begin
                if (slot_free) begin
                    n_out       = '{1'b0, 1'b1, {OP_ORIENT, i_orient}, 1'b0};
                    n_out_valid = 1'b1;
                    n_sent      = i_orient;
                    n_state     = ST_COLCMD;
                end
            end
            ST_COLCMD: begin
                if (slot_free) begin
                    n_out       = '{1'b0, 1'b0, {8'h00, OP_COLWIN}, 1'b0};
                    n_out_valid = 1'b1;
                    n_state     = ST_X0;
                end
            end
            ST_X0: begin
                if (slot_free) begin
                    n_out       = '{1'b1, 1'b1, {8'h00, r_cx}, 1'b0};
                    n_out_valid = 1'b1;
                    n_state     = ST_X1;
                end
            end
            ST_X1: begin
                if (slot_free) begin
                    n_out = '{1'b1, 1'b1, {8'h00, r_cx} + 16'(GLYPH_COLS - 1), 1'b0};
                    n_out_valid = 1'b1;
                    n_state     = ST_ROWCMD;
                end
            end
            ST_ROWCMD: begin
                if (slot_free) begin
                    n_out       = '{1'b0, 1'b0, {8'h00, OP_ROWWIN}, 1'b0};
                    n_out_valid = 1'b1;
                    n_state     = ST_Y0;
                end
            end
            ST_Y0: begin
                if (slot_free) begin
                    n_out       = '{1'b1, 1'b1, {8'h00, r_cy}, 1'b0};
                    n_out_valid = 1'b1;
                    n_state     = ST_Y1;
                end
            end
            ST_Y1: begin
                if (slot_free) begin
                    n_out = '{1'b1, 1'b1, {8'h00, r_cy} + 16'(GLYPH_ROWS - 1), 1'b0};
                    n_out_valid = 1'b1;
                    n_state     = ST_MEMWR;
                end
            end
            ST_MEMWR: begin
                if (slot_free) begin
                    n_out       = '{1'b0, 1'b0, {8'h00, OP_MEMWR}, 1'b0};
                    n_out_valid = 1'b1;
                    n_state     = ST_PIXEL;
                end
            end
            ST_PIXEL: begin
                if (slot_free) begin
                    n_out       = '{1'b1, 1'b1, pix_bit ? r_fg : r_bg, pix_last};
                    n_out_valid = 1'b1;
                    if (r_pcol == LAST_COL) begin
                        n_pcol = '0;
                        n_prow = r_prow + 3'd1;
                    end else begin
                        n_pcol = r_pcol + 3'd1;
                    end
                    if (pix_last) begin
                        n_cx    = wrap_nx[7:0];
                        n_cy    = wrap_ny[7:0];
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_idle      = (r_state == ST_IDLE);
    assign o_out       = r_out;
    assign o_out_valid = r_out_valid;

endmodule

// File: sv/lcd_text_glyph_streamer.sv
// Text glyph streamer: characters in, display-controller transfers out.
// Input channel (i_in_valid / o_in_ready) carries one transaction per item.
// A load item writes one font byte (if its address is in range) and gives no output.
// A draw item gives 47 or 48 output transactions: an optional orientation
// update, column window, row window, memory-write command and 40 pixels.
// A draw is first taken into the state register, and its first output
// transaction is registered from that state. The output register
// (o_out_valid / i_out_ready) issues at most one transaction per cycle;
// the next item is taken in the cycle after its last pixel is registered,
// while that pixel still waits to be taken.
// Glyph columns are fetched from the font RAM, one read per cycle, during
// the header transfers; the output register sets the rate.
// A receiver stall holds the output transaction and freezes the sequence.
// Reset (synchronous, active low) puts the cursor at (1,1), clears the
// orientation register and sets the last-sent orientation to 0xC8.
// Font RAM contents are not cleared by reset and must be loaded before use.
// cfg writes (i_cfg_we) must be issued only while nothing is in flight.
`include "lcd_text_glyph_streamer_defines.svh"

module lcd_text_glyph_streamer #(
    parameter int SCREEN_WIDTH  = ltgs_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = ltgs_pkg::SCREEN_HEIGHT_DEF,
    parameter int GLYPH_COUNT   = ltgs_pkg::GLYPH_COUNT_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [7:0]          i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  ltgs_pkg::t_in_item  i_in,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output ltgs_pkg::t_out_item o_out
);
    import ltgs_pkg::*;

    localparam int DEPTH = GLYPH_COUNT * GLYPH_COLS;

    logic       r_orient;
    logic [7:0] r_orient_val;
    logic       in_accept, draw_start, idle;
    logic [7:0] rd_data;
    logic [8:0] rd_addr;
    t_mem_req   mem_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_orient_val <= 8'h00;
        end else if (i_cfg_we) begin
            r_orient_val <= i_cfg_data;
        end
    end

    // marks that a cfg write landed; used only by the idle check below
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_orient <= 1'b0;
        end else begin
            r_orient <= i_cfg_we;
        end
    end

    assign in_accept  = i_in_valid && o_in_ready;
    assign draw_start = in_accept && (i_in.kind == KIND_DRAW);

    assign mem_req.we    = in_accept && (i_in.kind == KIND_LOAD) &&
                           ({1'b0, i_in.font_address} < 10'(DEPTH));
    assign mem_req.waddr = i_in.font_address;
    assign mem_req.wdata = i_in.font_byte;
    assign mem_req.raddr = rd_addr;

    ltgs_font_mem #(
        .GLYPH_COUNT (GLYPH_COUNT)
    ) u_font_mem (
        .i_clk     (i_clk),
        .i_req     (mem_req),
        .o_rd_data (rd_data)
    );

    ltgs_engine #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .GLYPH_COUNT   (GLYPH_COUNT)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (draw_start),
        .i_item      (i_in),
        .i_orient    (r_orient_val),
        .o_idle      (idle),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data),
        .o_out       (o_out),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready)
    );

    assign o_in_ready = idle;

    `LTGS_ASSERT_NXT(a_draw_busy, i_clk, i_rst_n, draw_start, !o_in_ready,
        "draw accepted while idle persists")
    `LTGS_ASSERT_IMP(a_idle_out, i_clk, i_rst_n, o_in_ready, !o_out_valid || o_out.last,
        "idle with partial character pending")
    `LTGS_ASSERT_NXT(a_cfg_idle, i_clk, i_rst_n, r_orient && !o_in_ready,
        !o_in_ready || o_out_valid, "cfg write tracking broken")

endmodule
